@@ design/assert_macros.svh @@
// Assertion macros for the cache tag store; only lbcm_ctrl includes them.
// Each use expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication on the same edge, skipped while in reset.
`define LBCM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lbcm assertion failed");

// Condition at one edge implies a consequence at the next edge.
`define LBCM_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error("lbcm assertion failed");

`endif

@@ design/lbcm_pkg.sv @@
// Package for the block cache tag store: constants, codes and shared types.
// No dependencies.
package lbcm_pkg;

  localparam int ENTRIES       = 32;
  localparam int IDX_W         = $clog2(ENTRIES);
  localparam int MIRROR_OFFSET = 32768;
  localparam int CFG_IDX_W     = 8;

  localparam logic [IDX_W-1:0]     SCAN_LAST        = IDX_W'(ENTRIES - 1);
  localparam logic [7:0]           REFS_MAX         = 8'hFF;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILED_DISK  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FAILED_BLOCK = CFG_IDX_W'(1);
  localparam logic [1:0]           DISK_PRIMARY     = 2'b00;
  localparam logic [1:0]           DISK_MIRROR      = 2'b01;

  typedef enum logic [2:0] {
    ACT_READ    = 3'd0,
    ACT_WRITE   = 3'd1,
    ACT_RELEASE = 3'd2,
    ACT_PIN     = 3'd3,
    ACT_UNPIN   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOFREE    = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    DOP_NONE  = 2'd0,
    DOP_READ  = 2'd1,
    DOP_WRITE = 2'd2
  } disk_op_e;

  typedef enum logic [1:0] {
    REF_KEEP,
    REF_INC,
    REF_DEC,
    REF_ONE
  } refs_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_EMIT0,
    S_EMIT1
  } state_e;

  typedef struct packed {
    logic             hit;
    logic             hit_valid;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] hit_rank;
    logic             free;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] free_rank;
  } cand_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             load_tag;
    logic [7:0]       dev;
    logic [14:0]      blk;
    logic             set_valid;
    refs_op_e         refs_op;
    logic             front;
    logic [IDX_W-1:0] front_rank;
  } upd_t;

  typedef struct packed {
    logic [7:0]       dev;
    logic [14:0]      blk;
    logic             valid;
    logic [7:0]       refs;
    logic [IDX_W-1:0] rank;
  } entry_t;

  typedef struct packed {
    logic [4:0]  slot;
    status_e     status;
    disk_op_e    disk_op;
    logic [15:0] disk_block;
    logic        last;
  } result_t;

  function automatic logic [15:0] mirror_of(input logic [15:0] blk);
    logic [16:0] sum;
    sum = 17'(blk) + 17'(MIRROR_OFFSET);
    return sum[15:0];
  endfunction

endpackage

@@ design/lbcm_if.sv @@
// Handshake channels of the cache tag store: request, result and configuration.
// Depends on nothing.
interface lbcm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  device;
  logic [14:0] block_number;
  logic [4:0]  slot;
  modport source (output valid, action, device, block_number, slot, input ready);
  modport sink   (input valid, action, device, block_number, slot, output ready);
endinterface

interface lbcm_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  slot_out;
  logic [1:0]  status;
  logic [1:0]  disk_op;
  logic [15:0] disk_block;
  logic        last;
  modport source (output valid, slot_out, status, disk_op, disk_block, last, input ready);
  modport sink   (input valid, slot_out, status, disk_op, disk_block, last, output ready);
endinterface

interface lbcm_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/lru_block_cache_with_mirror.sv @@
// Disk block buffer cache tag store with LRU recycling and RAID-1 mirror writes.
// Depends on lbcm_pkg, lbcm_if, lbcm_cell, lbcm_ctrl.
// One request at a time. A read passes through the scan state and then the decide
// state before its result: the lookup candidate walks the row of entry cells one cell
// per cycle. Write, release, pin and unpin skip the scan, and a write with two disk
// copies emits a second result after the first. The input is ready again once the
// state returns to idle after the last result is loaded into the output register;
// a stalled output holds the request in the emit states.
module lru_block_cache_with_mirror (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbcm_in_if.sink    in_i,
  lbcm_out_if.source out_o,
  lbcm_cfg_if.sink   cfg_i
);
  import lbcm_pkg::*;

  cand_t       cand [ENTRIES+1];
  entry_t      entries [ENTRIES];
  upd_t        upd;
  logic [7:0]  req_dev;
  logic [14:0] req_blk;

  assign cand[0] = '0;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    lbcm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (IDX_W'(k)),
      .req_dev_i (req_dev),
      .req_blk_i (req_blk),
      .cand_i    (cand[k]),
      .upd_i     (upd),
      .cand_o    (cand[k+1]),
      .entry_o   (entries[k])
    );
  end

  lbcm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .cfg_i     (cfg_i),
    .cand_i    (cand[ENTRIES]),
    .entries_i (entries),
    .upd_o     (upd),
    .req_dev_o (req_dev),
    .req_blk_o (req_blk)
  );

endmodule

@@ design/lbcm_cell.sv @@
// One cache entry: tag, valid, reference count and recency rank.
// Depends on lbcm_pkg; passes the lookup candidate to its neighbor each cycle.
module lbcm_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [lbcm_pkg::IDX_W-1:0] idx_i,
  input  logic [7:0]                req_dev_i,
  input  logic [14:0]               req_blk_i,
  input  lbcm_pkg::cand_t           cand_i,
  input  lbcm_pkg::upd_t            upd_i,
  output lbcm_pkg::cand_t           cand_o,
  output lbcm_pkg::entry_t          entry_o
);
  import lbcm_pkg::*;

  logic [7:0]       dev_q;
  logic [14:0]      blk_q;
  logic             valid_q;
  logic [7:0]       refs_q, refs_d;
  logic [IDX_W-1:0] rank_q;
  cand_t            cand_q, cand_d;
  logic             sel;

  assign sel = upd_i.en && (upd_i.idx == idx_i);

  always_comb begin
    cand_d = cand_i;
    if (dev_q == req_dev_i && blk_q == req_blk_i &&
        (!cand_i.hit || rank_q < cand_i.hit_rank)) begin
      cand_d.hit       = 1'b1;
      cand_d.hit_valid = valid_q;
      cand_d.hit_idx   = idx_i;
      cand_d.hit_rank  = rank_q;
    end
    if (refs_q == 8'd0 && (!cand_i.free || rank_q > cand_i.free_rank)) begin
      cand_d.free      = 1'b1;
      cand_d.free_idx  = idx_i;
      cand_d.free_rank = rank_q;
    end
  end

  always_comb begin
    refs_d = refs_q;
    case (upd_i.refs_op)
      REF_INC: if (refs_q != REFS_MAX) refs_d = refs_q + 8'd1;
      REF_DEC: if (refs_q != 8'd0) refs_d = refs_q - 8'd1;
      REF_ONE: refs_d = 8'd1;
      default: refs_d = refs_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q   <= '0;
      blk_q   <= '0;
      valid_q <= 1'b0;
      refs_q  <= '0;
      rank_q  <= SCAN_LAST - idx_i;
      cand_q  <= '0;
    end else begin
      cand_q <= cand_d;
      if (sel) begin
        if (upd_i.load_tag) begin
          dev_q <= upd_i.dev;
          blk_q <= upd_i.blk;
        end
        if (upd_i.set_valid) valid_q <= 1'b1;
        refs_q <= refs_d;
      end
      if (upd_i.en && upd_i.front) begin
        if (sel) begin
          rank_q <= '0;
        end else if (rank_q < upd_i.front_rank) begin
          rank_q <= rank_q + IDX_W'(1);
        end
      end
    end
  end

  assign cand_o  = cand_q;
  assign entry_o = '{dev: dev_q, blk: blk_q, valid: valid_q, refs: refs_q, rank: rank_q};

endmodule

@@ design/lbcm_ctrl.sv @@
// Sequencer of the cache tag store: request capture, chain scan, decision,
// result output register and failure configuration. Depends on lbcm_pkg, lbcm_if.
`include "assert_macros.svh"
module lbcm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  lbcm_in_if.sink                in_i,
  lbcm_out_if.source             out_o,
  lbcm_cfg_if.sink               cfg_i,
  input  lbcm_pkg::cand_t        cand_i,
  input  lbcm_pkg::entry_t       entries_i [lbcm_pkg::ENTRIES],
  output lbcm_pkg::upd_t         upd_o,
  output logic [7:0]             req_dev_o,
  output logic [14:0]            req_blk_o
);
  import lbcm_pkg::*;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] scan_cnt_q;
  logic [2:0]       act_q;
  logic [7:0]       dev_q;
  logic [14:0]      blk_q;
  logic [4:0]       slot_q;
  logic [1:0]       failed_disk_q;
  logic [15:0]      failed_block_q;
  result_t          res0_q, res1_q, res0_d, res1_d;
  logic             two_q, two_d;
  result_t          out_q;
  logic             out_valid_q;
  logic             out_free, load_out;
  result_t          out_d;
  entry_t           e;
  logic             in_range, forced, do0, do1, need_rd;
  logic [IDX_W-1:0] pick;
  logic [15:0]      p0;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_range = int'(slot_q) < ENTRIES;
  assign e        = entries_i[IDX_W'(slot_q)];
  assign forced   = (failed_disk_q == DISK_PRIMARY) || (failed_block_q == {1'b0, blk_q});
  assign p0       = {1'b0, e.blk};
  assign do0      = !((failed_disk_q == DISK_PRIMARY) || (failed_block_q == p0));
  assign do1      = failed_disk_q != DISK_MIRROR;
  assign pick     = cand_i.hit ? cand_i.hit_idx : cand_i.free_idx;
  assign need_rd  = (cand_i.hit ? !cand_i.hit_valid : 1'b1) || forced;

  always_comb begin
    res0_d = '{slot: slot_q, status: ST_OK, disk_op: DOP_NONE, disk_block: '0, last: 1'b1};
    res1_d = res0_d;
    two_d  = 1'b0;
    upd_o  = '0;
    upd_o.idx        = IDX_W'(slot_q);
    upd_o.dev        = dev_q;
    upd_o.blk        = blk_q;
    upd_o.refs_op    = REF_KEEP;
    upd_o.front_rank = e.rank;
    if (act_q == ACT_READ) begin
      if (!cand_i.hit && !cand_i.free) begin
        res0_d.slot   = '0;
        res0_d.status = ST_NOFREE;
      end else begin
        res0_d.slot = 5'(pick);
        if (need_rd) begin
          res0_d.disk_op    = DOP_READ;
          res0_d.disk_block = forced ? mirror_of({1'b0, blk_q}) : {1'b0, blk_q};
        end
        upd_o.en        = state_q == S_DECIDE;
        upd_o.idx       = pick;
        upd_o.load_tag  = !cand_i.hit;
        upd_o.set_valid = 1'b1;
        upd_o.refs_op   = cand_i.hit ? REF_INC : REF_ONE;
      end
    end else if (in_range) begin
      case (act_q)
        ACT_WRITE: begin
          if (do0) begin
            res0_d.disk_op    = DOP_WRITE;
            res0_d.disk_block = p0;
            res0_d.last       = !do1;
            res1_d.disk_op    = DOP_WRITE;
            res1_d.disk_block = mirror_of(p0);
            two_d             = do1;
          end else if (do1) begin
            res0_d.disk_op    = DOP_WRITE;
            res0_d.disk_block = mirror_of(p0);
          end
        end
        ACT_PIN: begin
          upd_o.en      = state_q == S_DECIDE;
          upd_o.refs_op = REF_INC;
        end
        ACT_RELEASE, ACT_UNPIN: begin
          if (e.refs == 8'd0) begin
            res0_d.status = ST_UNDERFLOW;
          end else begin
            upd_o.en      = state_q == S_DECIDE;
            upd_o.refs_op = REF_DEC;
            upd_o.front   = (act_q == ACT_RELEASE) && (e.refs == 8'd1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    out_d    = res0_q;
    case (state_q)
      S_IDLE: if (in_i.valid) state_d = (in_i.action == ACT_READ) ? S_SCAN : S_DECIDE;
      S_SCAN: if (scan_cnt_q == SCAN_LAST) state_d = S_DECIDE;
      S_DECIDE: state_d = S_EMIT0;
      S_EMIT0: if (out_free) begin
        load_out = 1'b1;
        state_d  = two_q ? S_EMIT1 : S_IDLE;
      end
      S_EMIT1: if (out_free) begin
        load_out = 1'b1;
        out_d    = res1_q;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q     <= '0;
      out_valid_q    <= 1'b0;
      two_q          <= 1'b0;
      failed_disk_q  <= 2'b11;
      failed_block_q <= 16'hFFFF;
    end else begin
      if (cfg_i.valid) begin
        if (cfg_i.index == CFG_FAILED_DISK) failed_disk_q <= cfg_i.data[1:0];
        if (cfg_i.index == CFG_FAILED_BLOCK) failed_block_q <= cfg_i.data;
      end
      scan_cnt_q <= (state_q == S_SCAN) ? scan_cnt_q + IDX_W'(1) : '0;
      if (state_q == S_DECIDE) two_q <= two_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      act_q  <= in_i.action;
      dev_q  <= in_i.device;
      blk_q  <= in_i.block_number;
      slot_q <= in_i.slot;
    end
    if (state_q == S_DECIDE) begin
      res0_q <= res0_d;
      res1_q <= res1_d;
    end
    if (load_out) out_q <= out_d;
  end

  assign in_i.ready       = state_q == S_IDLE;
  assign cfg_i.ready      = 1'b1;
  assign req_dev_o        = dev_q;
  assign req_blk_o        = blk_q;
  assign out_o.valid      = out_valid_q;
  assign out_o.slot_out   = out_q.slot;
  assign out_o.status     = out_q.status;
  assign out_o.disk_op    = out_q.disk_op;
  assign out_o.disk_block = out_q.disk_block;
  assign out_o.last       = out_q.last;

  `LBCM_ASSERT(a_upd_in_decide, upd_o.en |-> state_q == S_DECIDE)
  `LBCM_ASSERT(a_underflow_no_disk, (out_valid_q && out_q.status == ST_UNDERFLOW) |-> out_q.disk_op == DOP_NONE)
  `LBCM_ASSERT(a_second_only_if_two, state_q == S_EMIT1 |-> two_q)
  `LBCM_ASSERT_NEXT(a_scan_ends, state_q == S_SCAN && scan_cnt_q == SCAN_LAST, state_q == S_DECIDE)

endmodule
